FILE: sv/ofb_pkg.sv
// Shared types and constants for the overlap feather blend core.
// No dependencies; every other file in sv/ refers to this package by scoped names.

package ofb_pkg;

    localparam int PIX_W     = 8;
    localparam int COL_W     = 12;
    localparam int CFG_W     = 12;
    localparam int IDX_W     = 2;
    localparam int RAMP_W    = 12;
    localparam int MAX_WIDTH = 4096;
    // ramp span end - begin reaches 4095 + 2048, so one more bit than a column
    localparam int W_W       = COL_W + 1;
    localparam int NUM_W     = PIX_W + W_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DSH_W     = W_W + DIV_STEPS - 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(MAX_WIDTH - 1);

    localparam logic [IDX_W-1:0] REG_OVERLAP_WIDTH = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BLEND_WIDTH   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_FIRST_IMAGE   = IDX_W'(2);

    typedef struct packed {
        logic             plane;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] new_first;
        logic [PIX_W-1:0] old_first;
        logic [PIX_W-1:0] new_second;
        logic [PIX_W-1:0] old_second;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_first;
        logic [PIX_W-1:0] out_second;
    } out_item_t;

    typedef enum logic {
        TK_COPY,
        TK_BLEND
    } task_kind_t;

    // One classified request. For TK_COPY the result already sits in new_*.
    typedef struct packed {
        task_kind_t       kind;
        logic [W_W-1:0]   n;
        logic [W_W-1:0]   w;
        logic [PIX_W-1:0] new_first;
        logic [PIX_W-1:0] old_first;
        logic [PIX_W-1:0] new_second;
        logic [PIX_W-1:0] old_second;
    } task_t;

endpackage

FILE: sv/ofb_front.sv
// Front end: configuration registers, ramp counter and request classification.
// Depends on ofb_pkg; feeds ofb_queue.

module ofb_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [ofb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ofb_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        accept,
    input  ofb_pkg::in_item_t           in_item,
    output ofb_pkg::task_t              task_out
);

    logic [ofb_pkg::CFG_W-1:0]  overlap_width_reg;
    logic [ofb_pkg::CFG_W-1:0]  blend_width_reg;
    logic                       first_image_reg;
    logic [ofb_pkg::RAMP_W-1:0] ramp_count_reg;
    logic [ofb_pkg::RAMP_W-1:0] ramp_count_next;

    logic signed [ofb_pkg::CFG_W:0]   diff;
    logic signed [ofb_pkg::CFG_W:0]   lo_edge;
    logic        [ofb_pkg::CFG_W:0]   sum;
    logic        [ofb_pkg::COL_W-1:0] hi_edge;
    logic signed [ofb_pkg::W_W:0]     span;
    logic signed [ofb_pkg::W_W:0]     col_s;
    logic        [ofb_pkg::W_W-1:0]   w_u;
    logic        [ofb_pkg::RAMP_W-1:0] n_eff;
    logic                             past_lo;
    logic                             in_ramp;
    logic [ofb_pkg::PIX_W-1:0]        ns;
    logic [ofb_pkg::PIX_W-1:0]        os;

    always_comb
    begin
        diff    = $signed({1'b0, overlap_width_reg}) - $signed({1'b0, blend_width_reg});
        lo_edge = diff >>> 1;
        sum     = {1'b0, overlap_width_reg} + {1'b0, blend_width_reg};
        hi_edge = sum[ofb_pkg::CFG_W:1];
        span    = $signed({2'b00, hi_edge}) - $signed({lo_edge[ofb_pkg::CFG_W], lo_edge});
        w_u     = span[ofb_pkg::W_W-1:0];
        col_s   = $signed({2'b00, in_item.column});
        past_lo = col_s > $signed({lo_edge[ofb_pkg::CFG_W], lo_edge});
        // column above begin and below end already implies a positive span
        in_ramp = past_lo && (in_item.column < hi_edge);
        n_eff   = (in_item.column == '0) ? '0 : ramp_count_reg;
        ns      = in_item.plane ? in_item.new_second : '0;
        os      = in_item.plane ? in_item.old_second : '0;

        task_out.kind       = ofb_pkg::TK_COPY;
        task_out.n          = '0;
        task_out.w          = w_u;
        task_out.new_first  = in_item.new_first;
        task_out.old_first  = in_item.old_first;
        task_out.new_second = ns;
        task_out.old_second = os;
        ramp_count_next     = n_eff;

        priority if (first_image_reg)
        begin
            task_out.kind = ofb_pkg::TK_COPY;
        end
        else if (!past_lo)
        begin
            task_out.new_first  = in_item.old_first;
            task_out.new_second = os;
        end
        else if (in_ramp)
        begin
            task_out.kind = ofb_pkg::TK_BLEND;
            task_out.n    = ({1'b0, n_eff} > w_u) ? w_u : {1'b0, n_eff};
            if (n_eff < ofb_pkg::RAMP_MAX)
                ramp_count_next = n_eff + 1'b1;
        end
        else
        begin
            task_out.kind = ofb_pkg::TK_COPY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_width_reg <= '0;
            blend_width_reg   <= '0;
            first_image_reg   <= 1'b0;
            ramp_count_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ofb_pkg::REG_OVERLAP_WIDTH: overlap_width_reg <= cfg_data;
                    ofb_pkg::REG_BLEND_WIDTH:   blend_width_reg   <= cfg_data;
                    ofb_pkg::REG_FIRST_IMAGE:   first_image_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
                ramp_count_reg <= ramp_count_next;
        end
    end

    a_blend_weight_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && task_out.kind == ofb_pkg::TK_BLEND) |-> (task_out.n <= task_out.w))
        else $error("blend weight exceeds ramp span");

    a_col0_restarts_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.column == '0 && task_out.kind == ofb_pkg::TK_COPY)
        |=> (ramp_count_reg == '0))
        else $error("column 0 did not restart the ramp");

    a_blend_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && task_out.kind == ofb_pkg::TK_BLEND) |-> (task_out.w != '0))
        else $error("blend request with empty ramp");

endmodule

FILE: sv/ofb_queue.sv
// Short request queue between the classifying front end and the blend back end.
// Depends on ofb_pkg for the request type and depth.

module ofb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  ofb_pkg::task_t wr_data,
    input  logic           rd,
    output ofb_pkg::task_t rd_data,
    output logic           full,
    output logic           empty
);

    ofb_pkg::task_t               mem [ofb_pkg::QDEPTH];
    logic [ofb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ofb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ofb_pkg::QPTR_W:0]     count_reg;
    logic                         do_wr;
    logic                         do_rd;

    assign full    = (count_reg == (ofb_pkg::QPTR_W + 1)'(ofb_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == ofb_pkg::QPTR_W'(ofb_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == ofb_pkg::QPTR_W'(ofb_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (ofb_pkg::QPTR_W + 1)'(ofb_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty at once");

    a_empty_ptrs_equal: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

FILE: sv/ofb_back.sv
// Back end: weighted sums, shared-step restoring divide and the result register.
// Depends on ofb_pkg; pulls requests from ofb_queue.

module ofb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ofb_pkg::task_t    q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output ofb_pkg::out_item_t out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    ofb_pkg::task_t                task_reg;
    logic [ofb_pkg::NUM_W-1:0]     rem_first_reg;
    logic [ofb_pkg::NUM_W-1:0]     rem_second_reg;
    logic [ofb_pkg::DSH_W-1:0]     dsh_reg;
    logic [ofb_pkg::STEP_W-1:0]    step_reg;
    logic [ofb_pkg::PIX_W-1:0]     q_first_reg;
    logic [ofb_pkg::PIX_W-1:0]     q_second_reg;
    logic                          out_valid_reg;
    ofb_pkg::out_item_t            out_item_reg;

    logic [ofb_pkg::W_W-1:0]       w_minus_n;
    logic [ofb_pkg::NUM_W-1:0]     num_first;
    logic [ofb_pkg::NUM_W-1:0]     num_second;
    logic [ofb_pkg::NUM_W-1:0]     dsh_ext;
    logic                          ge_first;
    logic                          ge_second;
    logic                          emit;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || pop);

    always_comb
    begin
        w_minus_n  = task_reg.w - task_reg.n;
        num_first  = ofb_pkg::NUM_W'(task_reg.new_first) * ofb_pkg::NUM_W'(task_reg.n)
                   + ofb_pkg::NUM_W'(task_reg.old_first) * ofb_pkg::NUM_W'(w_minus_n);
        num_second = ofb_pkg::NUM_W'(task_reg.new_second) * ofb_pkg::NUM_W'(task_reg.n)
                   + ofb_pkg::NUM_W'(task_reg.old_second) * ofb_pkg::NUM_W'(w_minus_n);
        dsh_ext    = {1'b0, dsh_reg};
        ge_first   = rem_first_reg >= dsh_ext;
        ge_second  = rem_second_reg >= dsh_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        task_reg     <= q_data;
                        q_first_reg  <= q_data.new_first;
                        q_second_reg <= q_data.new_second;
                        state_reg    <= (q_data.kind == ofb_pkg::TK_BLEND) ? S_MUL : S_EMIT;
                    end
                end
                S_MUL:
                begin
                    rem_first_reg  <= num_first;
                    rem_second_reg <= num_second;
                    dsh_reg        <= {task_reg.w, (ofb_pkg::DIV_STEPS - 1)'(0)};
                    step_reg       <= ofb_pkg::STEP_W'(ofb_pkg::DIV_STEPS - 1);
                    state_reg      <= S_DIV;
                end
                S_DIV:
                begin
                    // one quotient bit per lane per cycle, MSB first
                    if (ge_first)
                        rem_first_reg <= rem_first_reg - dsh_ext;
                    if (ge_second)
                        rem_second_reg <= rem_second_reg - dsh_ext;
                    q_first_reg  <= {q_first_reg[ofb_pkg::PIX_W-2:0], ge_first};
                    q_second_reg <= {q_second_reg[ofb_pkg::PIX_W-2:0], ge_second};
                    dsh_reg      <= dsh_reg >> 1;
                    step_reg     <= step_reg - 1'b1;
                    if (step_reg == '0)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_item_reg.out_first  <= q_first_reg;
                        out_item_reg.out_second <= q_second_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dsh_reg != '0))
        else $error("divide with zero divisor");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && task_reg.kind == ofb_pkg::TK_BLEND)
        |-> (rem_first_reg < ofb_pkg::NUM_W'(task_reg.w)
             && rem_second_reg < ofb_pkg::NUM_W'(task_reg.w)))
        else $error("divide left remainder not below divisor");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !pop) |=> (state_reg == S_EMIT))
        else $error("result overwritten while waiting");

endmodule

FILE: sv/overlap_feather_blend_core.sv
// Top level of the overlap feather blend core: front end, request queue, back end.
// Depends on ofb_pkg, ofb_front, ofb_queue and ofb_back.
//
//   channel   handshake          payload
//   input     push / full        in_item  (in_item_t)
//   result    empty / pop        out_item (out_item_t)
//   config    cfg_write          cfg_index, cfg_data
//
// The front end classifies a request and updates the ramp counter in the cycle it
// is taken; a two-entry queue holds requests for the back end.
// A copy request goes straight to the back end's result register; a ramp request
// passes a product step and 8 shared restoring divide steps before that register.
// full rises only when both queue entries wait; a result held by a low pop stalls
// the back end in its emit step. Reset clears control state and config registers.

module overlap_feather_blend_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  ofb_pkg::in_item_t         in_item,
    output logic                      empty,
    input  logic                      pop,
    output ofb_pkg::out_item_t        out_item,
    input  logic                      cfg_write,
    input  logic [ofb_pkg::IDX_W-1:0] cfg_index,
    input  logic [ofb_pkg::CFG_W-1:0] cfg_data
);

    ofb_pkg::task_t front_task;
    ofb_pkg::task_t q_data;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    ofb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_item   (in_item),
        .task_out  (front_task)
    );

    ofb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_data (front_task),
        .rd      (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    ofb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

endmodule

FILE: tb/tb_overlap_feather_blend_core.sv
// Self-checking bench for overlap_feather_blend_core: a directed table, random row sweeps
// and a long ramp run, scored against table values or a cycle-free blend predictor.
// Depends on ofb_pkg and the core RTL only.

module tb_overlap_feather_blend_core;

    localparam int QUIET_LIMIT = 4000;   // above the longest receiver hold plus block and gap time
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;
    localparam int PHASES      = 20;
    localparam int PHASE_REQS  = 48;
    localparam int SAT_REQS    = 260;

    typedef struct {
        bit                                is_cfg;
        logic [ofb_pkg::IDX_W-1:0]         idx;
        logic [ofb_pkg::CFG_W-1:0]         val;
        ofb_pkg::in_item_t                 px;
        bit                                typed;
        ofb_pkg::out_item_t                want;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    ofb_pkg::in_item_t          in_item;
    logic                       empty;
    logic                       pop;
    ofb_pkg::out_item_t         out_item;
    logic                       cfg_write;
    logic [ofb_pkg::IDX_W-1:0]  cfg_index;
    logic [ofb_pkg::CFG_W-1:0]  cfg_data;

    // predictor state
    logic [ofb_pkg::CFG_W-1:0]  ovl_reg;
    logic [ofb_pkg::CFG_W-1:0]  blw_reg;
    logic                       first_img_reg;
    logic [ofb_pkg::RAMP_W-1:0] ramp_pos;

    ofb_pkg::out_item_t pending_px[$];
    dir_row_t           script[$];
    int                 err_count;
    int                 n_req;
    int                 n_checked;
    int                 n_settings;
    int                 burst_left;
    bit                 offering;
    logic               hold_req;

    overlap_feather_blend_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Blend of one request; advances the ramp position like the block does.
    function automatic ofb_pkg::out_item_t blend_predict(input ofb_pkg::in_item_t it);
        int                 lo;
        int                 hi;
        int                 span;
        int                 col;
        int                 n;
        int                 new_a;
        int                 old_a;
        int                 new_b;
        int                 old_b;
        ofb_pkg::out_item_t r;
        col   = int'(it.column);
        new_a = int'(it.new_first);
        old_a = int'(it.old_first);
        new_b = it.plane ? int'(it.new_second) : 0;
        old_b = it.plane ? int'(it.old_second) : 0;
        lo    = (int'(ovl_reg) - int'(blw_reg)) >>> 1;
        hi    = (int'(ovl_reg) + int'(blw_reg)) >>> 1;
        span  = hi - lo;
        if (col == 0)
            ramp_pos = '0;
        if (first_img_reg)
        begin
            r.out_first  = ofb_pkg::PIX_W'(new_a);
            r.out_second = ofb_pkg::PIX_W'(new_b);
        end
        else if (col <= lo)
        begin
            r.out_first  = ofb_pkg::PIX_W'(old_a);
            r.out_second = ofb_pkg::PIX_W'(old_b);
        end
        else if (col < hi && span > 0)
        begin
            n = (int'(ramp_pos) > span) ? span : int'(ramp_pos);
            r.out_first  = ofb_pkg::PIX_W'((new_a * n + old_a * (span - n)) / span);
            r.out_second = ofb_pkg::PIX_W'((new_b * n + old_b * (span - n)) / span);
            if (ramp_pos != ofb_pkg::RAMP_MAX)
                ramp_pos = ramp_pos + 1'b1;
        end
        else
        begin
            r.out_first  = ofb_pkg::PIX_W'(new_a);
            r.out_second = ofb_pkg::PIX_W'(new_b);
        end
        if (!it.plane)
            r.out_second = '0;
        return r;
    endfunction

    function automatic ofb_pkg::in_item_t random_px(input logic plane, input int col);
        ofb_pkg::in_item_t it;
        it.plane      = plane;
        it.column     = ofb_pkg::COL_W'(col);
        it.new_first  = ofb_pkg::PIX_W'($urandom);
        it.old_first  = ofb_pkg::PIX_W'($urandom);
        it.new_second = ofb_pkg::PIX_W'($urandom);
        it.old_second = ofb_pkg::PIX_W'($urandom);
        return it;
    endfunction

    function automatic logic [ofb_pkg::CFG_W-1:0] pick_corner();
        case ($urandom_range(0, 3))
            0:       return ofb_pkg::CFG_W'(0);
            1:       return ofb_pkg::CFG_W'(1);
            2:       return ofb_pkg::CFG_W'(4094);
            default: return ofb_pkg::CFG_W'(4095);
        endcase
    endfunction

    function automatic void add_cfg(input logic [ofb_pkg::IDX_W-1:0] idx, input int val);
        dir_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = ofb_pkg::CFG_W'(val);
        script.push_back(row);
    endfunction

    function automatic void add_px(input logic plane, input int col, input int nf, input int of,
                                   input int ns, input int os, input bit typed,
                                   input int wf, input int ws);
        dir_row_t row;
        row                 = '{default: '0};
        row.px.plane        = plane;
        row.px.column       = ofb_pkg::COL_W'(col);
        row.px.new_first    = ofb_pkg::PIX_W'(nf);
        row.px.old_first    = ofb_pkg::PIX_W'(of);
        row.px.new_second   = ofb_pkg::PIX_W'(ns);
        row.px.old_second   = ofb_pkg::PIX_W'(os);
        row.typed           = typed;
        row.want.out_first  = ofb_pkg::PIX_W'(wf);
        row.want.out_second = ofb_pkg::PIX_W'(ws);
        script.push_back(row);
    endfunction

    task automatic drop_push();
        if (offering)
            push <= 1'b0;
        offering = 1'b0;
    endtask

    // Offer one request, wait for it to be taken, then maybe open a gap.
    task automatic offer(input ofb_pkg::in_item_t it, input bit typed,
                         input ofb_pkg::out_item_t want);
        ofb_pkg::out_item_t pred;
        int                 gap;
        push     <= 1'b1;
        in_item  <= it;
        offering  = 1'b1;
        do
            @(posedge clk);
        while (full);
        pred = blend_predict(it);
        pending_px.push_back(typed ? want : pred);
        n_req++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(20, 40);
            else
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                drop_push();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic offer_px(input ofb_pkg::in_item_t it);
        offer(it, 1'b0, '0);
    endtask

    // Register writes only with nothing in flight.
    task automatic wait_idle();
        drop_push();
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ofb_pkg::IDX_W-1:0] idx,
                             input logic [ofb_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            ofb_pkg::REG_OVERLAP_WIDTH: ovl_reg       = val;
            ofb_pkg::REG_BLEND_WIDTH:   blw_reg       = val;
            ofb_pkg::REG_FIRST_IMAGE:   first_img_reg = val[0];
            default: ;
        endcase
        n_settings++;
    endtask

    // Mostly rows swept from column 0 through the ramp, some sweeps that skip
    // column 0, and stray requests anywhere.
    task automatic run_phase(input int budget);
        int kind;
        int hi;
        int lim;
        int stride;
        int col;
        while (budget > 0)
        begin
            kind   = $urandom_range(0, 9);
            hi     = (int'(ovl_reg) + int'(blw_reg)) >>> 1;
            lim    = (hi + 4 > 4095) ? 4095 : hi + 4;
            stride = lim / 40 + 1;
            if (kind == 9)
            begin
                offer_px(random_px($urandom_range(0, 1), $urandom_range(0, 4095)));
                budget--;
            end
            else
            begin
                col = (kind < 7) ? 0 : $urandom_range(1, lim);
                do
                begin
                    offer_px(random_px(1'b0, col));
                    budget--;
                    if (col % 2 == 0 && budget > 0 && $urandom_range(0, 1) == 1)
                    begin
                        offer_px(random_px(1'b1, col));
                        budget--;
                    end
                    col += $urandom_range(1, stride);
                end
                while (col <= lim && budget > 0);
            end
        end
    endtask

    // Receiver: checks each taken result and stalls in changing patterns.
    initial
    begin : result_side
        int                 seg_left;
        int                 mode;
        int                 every;
        int                 phase_cnt;
        int                 hold_left;
        ofb_pkg::out_item_t want;
        seg_left  = 0;
        mode      = 0;
        every     = 2;
        phase_cnt = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                n_checked++;
                if (pending_px.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: result %0h/%0h with no request waiting",
                                 out_item.out_first, out_item.out_second);
                end
                else
                begin
                    want = pending_px.pop_front();
                    if (out_item.out_first !== want.out_first ||
                        out_item.out_second !== want.out_second)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"ERROR: result %0d: first exp %0h got %0h, ",
                                      "second exp %0h got %0h"},
                                     n_checked, want.out_first, out_item.out_first,
                                     want.out_second, out_item.out_second);
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 200);
                    mode     = $urandom_range(0, 3);
                    every    = $urandom_range(2, 6);
                end
                seg_left--;
                phase_cnt++;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= $urandom_range(0, 1);
                    2:       pop <= (phase_cnt % every == 0);
                    default: pop <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles in which no request and no result is taken.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int                        k;
        int                        n_directed;
        dir_row_t                  row;
        ofb_pkg::in_item_t         it;
        logic [ofb_pkg::CFG_W-1:0] ow;
        logic [ofb_pkg::CFG_W-1:0] bw;

        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        in_item       = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        ovl_reg       = '0;
        blw_reg       = '0;
        first_img_reg = 1'b0;
        ramp_pos      = '0;
        err_count     = 0;
        n_req         = 0;
        n_checked     = 0;
        n_settings    = 0;
        burst_left    = 1;
        offering      = 1'b0;

        // reset widths: begin = end = 0, so column 0 keeps old and the rest take new
        add_px(1'b0, 0,    8'hFF, 8'h00, 8'hFF, 8'hFF, 1, 8'h00, 8'h00);
        add_px(1'b1, 0,    8'h00, 8'hFF, 8'hFF, 8'h00, 1, 8'hFF, 8'h00);
        add_px(1'b0, 4095, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 1, 8'hA5, 8'h00);
        add_px(1'b1, 4094, 8'h00, 8'hFF, 8'hFF, 8'h00, 1, 8'h00, 8'hFF);
        // widest ramp: begin 0, end 4095
        add_cfg(ofb_pkg::REG_OVERLAP_WIDTH, 4095);
        add_cfg(ofb_pkg::REG_BLEND_WIDTH, 4095);
        add_px(1'b0, 0,    8'hFF, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00);
        add_px(1'b0, 1,    8'hFF, 8'h00, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b1, 2,    8'hFF, 8'h00, 8'h00, 8'hFF, 0, 0, 0);
        add_px(1'b0, 4094, 8'hFF, 8'hFF, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b0, 4095, 8'h3C, 8'hC3, 8'h00, 8'h00, 1, 8'h3C, 8'h00);
        // blend wider than overlap: negative begin
        add_cfg(ofb_pkg::REG_OVERLAP_WIDTH, 0);
        add_px(1'b1, 0,    8'hFF, 8'h00, 8'h00, 8'hFF, 0, 0, 0);
        add_px(1'b0, 2046, 8'h80, 8'h7F, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b0, 2047, 8'h12, 8'h34, 8'h00, 8'h00, 1, 8'h12, 8'h00);
        // empty ramp
        add_cfg(ofb_pkg::REG_OVERLAP_WIDTH, 4095);
        add_cfg(ofb_pkg::REG_BLEND_WIDTH, 0);
        add_px(1'b0, 2047, 8'h11, 8'h22, 8'h00, 8'h00, 1, 8'h22, 8'h00);
        add_px(1'b1, 2048, 8'h11, 8'h22, 8'h33, 8'h44, 1, 8'h11, 8'h33);
        // ramp width 2: begin 1, end 3; repeated column 2 runs the counter past W
        add_cfg(ofb_pkg::REG_OVERLAP_WIDTH, 4);
        add_cfg(ofb_pkg::REG_BLEND_WIDTH, 2);
        add_px(1'b0, 0,    8'hC8, 8'h64, 8'h00, 8'h00, 1, 8'h64, 8'h00);
        add_px(1'b1, 1,    8'hC8, 8'h64, 8'h10, 8'hF0, 1, 8'h64, 8'hF0);
        add_px(1'b0, 2,    8'hC8, 8'h64, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b1, 2,    8'hC8, 8'h64, 8'h10, 8'hF0, 0, 0, 0);
        add_px(1'b0, 2,    8'hC8, 8'h65, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b0, 2,    8'hC9, 8'h64, 8'h00, 8'h00, 0, 0, 0);
        add_px(1'b0, 3,    8'h01, 8'hFE, 8'h00, 8'h00, 1, 8'h01, 8'h00);
        add_cfg(ofb_pkg::REG_FIRST_IMAGE, 1);
        add_px(1'b0, 1,    8'h77, 8'h88, 8'h00, 8'h00, 1, 8'h77, 8'h00);
        add_px(1'b1, 0,    8'h00, 8'hFF, 8'hFF, 8'h00, 1, 8'h00, 8'hFF);
        add_cfg(ofb_pkg::REG_FIRST_IMAGE, 0);
        add_px(1'b0, 2,    8'hFF, 8'h00, 8'h00, 8'h00, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                wait_idle();
                write_reg(row.idx, row.val);
                cfg_write <= 1'b0;
            end
            else
                offer(row.px, row.typed, row.want);
        end
        n_directed = n_req;

        for (k = 0; k < PHASES; k++)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    ow = ofb_pkg::CFG_W'($urandom_range(0, 40));
                    bw = ofb_pkg::CFG_W'($urandom_range(0, 40));
                end
                3:
                begin
                    ow = pick_corner();
                    bw = ofb_pkg::CFG_W'($urandom_range(0, 40));
                end
                4:
                begin
                    ow = pick_corner();
                    bw = pick_corner();
                end
                default:
                begin
                    ow = ofb_pkg::CFG_W'($urandom);
                    bw = ofb_pkg::CFG_W'($urandom);
                end
            endcase
            wait_idle();
            write_reg(ofb_pkg::REG_OVERLAP_WIDTH, ow);
            write_reg(ofb_pkg::REG_BLEND_WIDTH, bw);
            write_reg(ofb_pkg::REG_FIRST_IMAGE, ofb_pkg::CFG_W'($urandom_range(0, 7) == 0));
            cfg_write <= 1'b0;
            @(posedge clk);
            // one long result stall while requests keep coming
            if (k == 2)
                hold_req <= 1'b1;
            run_phase(PHASE_REQS);
        end

        // long ramp run without a restart at column 0
        wait_idle();
        write_reg(ofb_pkg::REG_OVERLAP_WIDTH, ofb_pkg::CFG_W'(4095));
        write_reg(ofb_pkg::REG_BLEND_WIDTH, ofb_pkg::CFG_W'(4095));
        write_reg(ofb_pkg::REG_FIRST_IMAGE, ofb_pkg::CFG_W'(0));
        cfg_write <= 1'b0;
        @(posedge clk);
        offer_px(random_px($urandom_range(0, 1), 0));
        for (k = 0; k < SAT_REQS; k++)
        begin
            it = random_px($urandom_range(0, 1), $urandom_range(1, 4094));
            offer_px(it);
        end

        drop_push();
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT * 2) @(posedge clk);

        $display("Summary: %0d requests (%0d directed, %0d in the long ramp run), %0d checked",
                 n_req, n_directed, SAT_REQS + 1, n_checked);
        $display("Summary: %0d register writes, %0d mismatches", n_settings, err_count);
        if (err_count == 0 && pending_px.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
